FILE: sv/longest_prefix_route_table_defines.svh
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared assertion forms for the route table checkers.
// ----------------------------------------------------------------------------
`ifndef LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH

// same-cycle implication
`define LPRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define LPRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

FILE: sv/lprt_pkg.sv
// ----------------------------------------------------------------------------
// Route table package
// Operation and status codes, register indexes and the token that walks
// the slot chain.
// ----------------------------------------------------------------------------
`default_nettype none

package lprt_pkg;

   localparam int ADDR_BITS = 32;
   localparam int LEN_BITS  = 6;
   localparam int CSR_IDX_BITS = 3;

   typedef enum logic [1:0] {
      OP_STORE  = 2'd0,
      OP_DELETE = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_INVALID   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   localparam logic [CSR_IDX_BITS-1:0] REG_DEFAULT_ENABLE    = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEFAULT_PRESENT   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEFAULT_GATEWAY   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEFAULT_INTERFACE = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEFAULT_METRIC    = 3'd4;

   typedef struct packed {
      logic                  active;
      op_type                op;
      logic                  invalid;
      logic [ADDR_BITS-1:0]  addr;
      logic [ADDR_BITS-1:0]  gateway;
      logic [LEN_BITS-1:0]   length;
      logic [7:0]            iface;
      logic [15:0]           metric;
      logic                  hit;
      logic [LEN_BITS-1:0]   best_length;
      logic [ADDR_BITS-1:0]  best_prefix;
      logic [ADDR_BITS-1:0]  best_gateway;
      logic [7:0]            best_iface;
      logic [15:0]           best_metric;
   } token_type;

endpackage

`default_nettype wire

FILE: sv/lprt_cell.sv
// ----------------------------------------------------------------------------
// Route table slot cell
// Holds one route slot and updates the passing token: claims a free slot on
// store, frees a matching slot on delete, keeps the longest match on lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module lprt_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lprt_pkg::token_type tok_i,
   output lprt_pkg::token_type    tok_o
);
   import lprt_pkg::*;

   logic                  valid_ff, valid_in;
   logic [ADDR_BITS-1:0]  prefix_ff;
   logic [LEN_BITS-1:0]   length_ff;
   logic [ADDR_BITS-1:0]  gateway_ff;
   logic [7:0]            iface_ff;
   logic [15:0]           metric_ff;
   logic                  write_slot;
   token_type             tok_ff, tok_in;
   logic [ADDR_BITS-1:0]  slot_mask;
   logic                  covers;

   assign slot_mask = ~({ADDR_BITS{1'b1}} >> length_ff);
   assign covers    = (tok_i.addr & slot_mask) == prefix_ff;

   always_comb begin
      tok_in     = tok_i;
      valid_in   = valid_ff;
      write_slot = 1'b0;
      if (tok_i.active) begin
         case (tok_i.op)
            OP_STORE: begin
               if (!tok_i.invalid && !tok_i.hit && !valid_ff) begin
                  write_slot = 1'b1;
                  valid_in   = 1'b1;
                  tok_in.hit = 1'b1;
               end
            end
            OP_DELETE: begin
               if (!tok_i.hit && valid_ff && prefix_ff == tok_i.addr &&
                   gateway_ff == tok_i.gateway) begin
                  valid_in   = 1'b0;
                  tok_in.hit = 1'b1;
               end
            end
            OP_LOOKUP: begin
               if (valid_ff && covers && (!tok_i.hit || length_ff > tok_i.best_length))
               begin
                  tok_in.hit          = 1'b1;
                  tok_in.best_length  = length_ff;
                  tok_in.best_prefix  = prefix_ff;
                  tok_in.best_gateway = gateway_ff;
                  tok_in.best_iface   = iface_ff;
                  tok_in.best_metric  = metric_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_slot) begin
         prefix_ff  <= tok_i.addr;
         length_ff  <= tok_i.length;
         gateway_ff <= tok_i.gateway;
         iface_ff   <= tok_i.iface;
         metric_ff  <= tok_i.metric;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

FILE: sv/longest_prefix_route_table.sv
// A request transfer is registered in the head register, then the token visits
// one slot cell per cycle along the chain; the answer is registered in rsp_ff.
// Only one request in flight: req_ready is low while the chain or pend_ff is busy.
// A second result register holds a finished answer while the response waits.
// Reset (synchronous, active high) clears all slots and the default route.
// ----------------------------------------------------------------------------
// Longest prefix route table
// IPv4 route store, delete and longest-prefix lookup over a chain of slot
// cells, with a configurable default route.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_route_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_address,
   input  wire logic [31:0] req_netmask,
   input  wire logic [31:0] req_next_hop,
   input  wire logic [7:0]  req_port_number,
   input  wire logic [15:0] req_cost,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_from_default,
   output logic [31:0]      rsp_route_prefix,
   output logic [5:0]       rsp_route_length,
   output logic [31:0]      rsp_route_gateway,
   output logic [7:0]       rsp_route_interface,
   output logic [15:0]      rsp_route_metric,
   input  wire logic        csr_write_enable,
   input  wire logic [lprt_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [31:0] csr_data
);
   import lprt_pkg::*;

   typedef struct packed {
      status_type           status;
      logic                 from_default;
      logic [ADDR_BITS-1:0] prefix;
      logic [LEN_BITS-1:0]  length;
      logic [ADDR_BITS-1:0] gateway;
      logic [7:0]           iface;
      logic [15:0]          metric;
   } result_type;

   function automatic logic [LEN_BITS-1:0] count_mask(input logic [31:0] m);
      logic [31:0] c1, c2, c3, c4, c5;
      c1 = m - ((m >> 1) & 32'h5555_5555);
      c2 = (c1 & 32'h3333_3333) + ((c1 >> 2) & 32'h3333_3333);
      c3 = (c2 + (c2 >> 4)) & 32'h0F0F_0F0F;
      c4 = c3 + (c3 >> 8);
      c5 = c4 + (c4 >> 16);
      return c5[LEN_BITS-1:0];
   endfunction

   logic        def_enable_ff, def_present_ff;
   logic [31:0] def_gateway_ff;
   logic [7:0]  def_iface_ff;
   logic [15:0] def_metric_ff;

   logic        busy_ff, busy_in;
   token_type   head_ff, head_in;
   token_type   chain [TABLE_ENTRIES+1];
   token_type   tail;

   result_type  result;
   result_type  rsp_ff, rsp_in, pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in, pend_valid_ff, pend_valid_in;
   logic        req_xfer, rsp_free;
   logic [31:0] inv_mask;

   // ---- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         def_enable_ff  <= 1'b0;
         def_present_ff <= 1'b0;
         def_gateway_ff <= '0;
         def_iface_ff   <= '0;
         def_metric_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_DEFAULT_ENABLE:    def_enable_ff  <= csr_data[0];
            REG_DEFAULT_PRESENT:   def_present_ff <= csr_data[0];
            REG_DEFAULT_GATEWAY:   def_gateway_ff <= csr_data;
            REG_DEFAULT_INTERFACE: def_iface_ff   <= csr_data[7:0];
            REG_DEFAULT_METRIC:    def_metric_ff  <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // ---- request intake
   assign req_ready = !busy_ff && !pend_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign inv_mask  = ~req_netmask;

   always_comb begin
      head_in              = '0;
      head_in.active       = req_xfer;
      head_in.op           = op_type'(req_op);
      head_in.invalid      = ((inv_mask & (inv_mask + 32'd1)) != '0) ||
                             ((req_address & inv_mask) != '0);
      head_in.addr         = req_address;
      head_in.gateway      = req_next_hop;
      head_in.length       = count_mask(req_netmask);
      head_in.iface        = req_port_number;
      head_in.metric       = req_cost;
   end

   always_comb begin
      busy_in = busy_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
      end else if (tail.active) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         head_ff.active <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         head_ff <= head_in;
      end
   end

   // ---- slot chain
   assign chain[0] = head_ff;

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      lprt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .tok_i (chain[g]),
         .tok_o (chain[g+1])
      );
   end

   assign tail = chain[TABLE_ENTRIES];

   // ---- answer
   always_comb begin
      result        = '0;
      result.status = ST_NOT_FOUND;
      case (tail.op)
         OP_STORE: begin
            if (tail.invalid) begin
               result.status = ST_INVALID;
            end else if (tail.hit) begin
               result.status = ST_OK;
            end else begin
               result.status = ST_FULL;
            end
         end
         OP_DELETE: begin
            if (tail.hit) begin
               result.status = ST_OK;
            end
         end
         OP_LOOKUP: begin
            if (tail.hit) begin
               result.status  = ST_OK;
               result.prefix  = tail.best_prefix;
               result.length  = tail.best_length;
               result.gateway = tail.best_gateway;
               result.iface   = tail.best_iface;
               result.metric  = tail.best_metric;
            end else if (def_enable_ff && def_present_ff) begin
               result.status       = ST_OK;
               result.from_default = 1'b1;
               result.gateway      = def_gateway_ff;
               result.iface        = def_iface_ff;
               result.metric       = def_metric_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (rsp_free && pend_valid_ff) begin
         rsp_in        = pend_ff;
         rsp_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end else if (tail.active) begin
         if (rsp_free) begin
            rsp_in       = result;
            rsp_valid_in = 1'b1;
         end else begin
            pend_in       = result;
            pend_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_ff.status;
   assign rsp_from_default    = rsp_ff.from_default;
   assign rsp_route_prefix    = rsp_ff.prefix;
   assign rsp_route_length    = rsp_ff.length;
   assign rsp_route_gateway   = rsp_ff.gateway;
   assign rsp_route_interface = rsp_ff.iface;
   assign rsp_route_metric    = rsp_ff.metric;

endmodule

`default_nettype wire

FILE: sv/lprt_checker.sv
// ----------------------------------------------------------------------------
// Route table port checker
// Checks response handshake and field consistency seen on the top ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "longest_prefix_route_table_defines.svh"

module lprt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_from_default,
   input wire logic [31:0] rsp_route_prefix,
   input wire logic [5:0]  rsp_route_length,
   input wire logic [31:0] rsp_route_gateway,
   input wire logic [7:0]  rsp_route_interface,
   input wire logic [15:0] rsp_route_metric
);
   import lprt_pkg::*;

   `LPRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `LPRT_ASSERT_NOW(a_default_shape, clock, reset, rsp_valid && rsp_from_default,
      rsp_status == ST_OK && rsp_route_prefix == '0 && rsp_route_length == '0)

   `LPRT_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status != ST_OK,
      !rsp_from_default && rsp_route_prefix == '0 && rsp_route_length == '0 &&
      rsp_route_gateway == '0 && rsp_route_interface == '0 && rsp_route_metric == '0)

   `LPRT_ASSERT_NOW(a_length_range, clock, reset, rsp_valid, rsp_route_length <= 6'd32)

endmodule

bind longest_prefix_route_table lprt_checker u_lprt_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_from_default    (rsp_from_default),
   .rsp_route_prefix    (rsp_route_prefix),
   .rsp_route_length    (rsp_route_length),
   .rsp_route_gateway   (rsp_route_gateway),
   .rsp_route_interface (rsp_route_interface),
   .rsp_route_metric    (rsp_route_metric)
);

`default_nettype wire
